>>> sv/dcsg_pkg.sv
// Shared types and constants for the drive command safety gate.
// No dependencies; imported by every module of the block.
package dcsg_pkg;

  localparam int FRAC_BITS = 14;
  localparam logic signed [15:0] ONE_Q  = 16'(1 << FRAC_BITS);
  localparam logic signed [15:0] HALF_Q = 16'(1 << (FRAC_BITS - 1));

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_LIMIT  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_REQ_NEUTRAL = CFG_IDX_W'(3);

  localparam logic [15:0] TIMEOUT_RST  = 16'd300;
  localparam logic [14:0] MAX_OUT_RST  = 15'd6554;
  localparam logic [14:0] DEADZONE_RST = 15'd819;

  localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;

  typedef enum logic [1:0] {
    REQ_DRIVE   = 2'd0,
    REQ_RESET   = 2'd1,
    REQ_TICK    = 2'd2,
    REQ_PUBLISH = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_DRIVE    = 3'd1,
    MODE_TIMEOUT  = 3'd2,
    MODE_ESTOP    = 3'd3,
    MODE_RST_OK   = 3'd4,
    MODE_RST_DENY = 3'd5
  } mode_t;

  typedef struct packed {
    logic [15:0] timeout_ms;
    logic [14:0] out_limit;
    logic [14:0] deadzone;
    logic        req_neutral;
  } cfg_t;

  typedef struct packed {
    req_t               req;
    logic signed [15:0] thr;
    logic signed [15:0] ste;
    logic signed [15:0] brk;
    logic               en;
    logic               es;
    logic [31:0]        seq;
  } item_t;

  typedef struct packed {
    logic               have_command;
    logic               estop_latch;
    logic [16:0]        elapsed_ms;
    logic signed [15:0] thr;
    logic signed [15:0] ste;
    logic signed [15:0] brk;
    logic               en;
    logic               es;
    logic [31:0]        seq;
    logic [31:0]        publish_count;
  } gate_state_t;

  typedef struct packed {
    logic signed [15:0] safe_throttle;
    logic signed [15:0] safe_steering;
    logic [14:0]        safe_brake;
    logic               safe_enable;
    logic               safe_estop;
    logic [31:0]        drive_seq;
    mode_t              mode;
    logic               failsafe;
    logic               link_ok;
    logic signed [15:0] left_drive;
    logic signed [15:0] right_drive;
    logic [31:0]        status_seq;
  } res_t;

endpackage

>>> sv/dcsg_state.sv
// Config registers and gate state (watchdog, estop latch, stored command).
// Depends on dcsg_pkg.
module dcsg_state import dcsg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept_i,
  input  item_t                 item_i,
  input  logic                  reset_ok_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o,
  output gate_state_t           st_o
);

  cfg_t        cfg_r, cfg_nxt;
  logic        have_r, have_nxt;
  logic        latch_r, latch_nxt;
  logic [16:0] elapsed_r, elapsed_nxt;
  logic [31:0] pub_r, pub_nxt;
  logic signed [15:0] thr_r, ste_r, brk_r;
  logic        en_r, es_r;
  logic [31:0] seq_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TIMEOUT_MS:  cfg_nxt.timeout_ms = cfg_data_i;
        CFG_OUT_LIMIT:   cfg_nxt.out_limit = cfg_data_i[14:0];
        CFG_DEADZONE:    cfg_nxt.deadzone = cfg_data_i[14:0];
        CFG_REQ_NEUTRAL: cfg_nxt.req_neutral = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    have_nxt    = have_r;
    latch_nxt   = latch_r;
    elapsed_nxt = elapsed_r;
    pub_nxt     = pub_r;
    if (accept_i) begin
      case (item_i.req)
        REQ_DRIVE: begin
          have_nxt    = 1'b1;
          elapsed_nxt = '0;
          latch_nxt   = latch_r | item_i.es;
        end
        REQ_TICK: begin
          if (elapsed_r != ELAPSED_MAX) elapsed_nxt = elapsed_r + 17'd1;
        end
        REQ_RESET: begin
          if (reset_ok_i) latch_nxt = 1'b0;
        end
        REQ_PUBLISH: pub_nxt = pub_r + 32'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r     <= '{timeout_ms: TIMEOUT_RST, out_limit: MAX_OUT_RST,
                     deadzone: DEADZONE_RST, req_neutral: 1'b1};
      have_r    <= 1'b0;
      latch_r   <= 1'b0;
      elapsed_r <= '0;
      pub_r     <= '0;
    end else begin
      cfg_r     <= cfg_nxt;
      have_r    <= have_nxt;
      latch_r   <= latch_nxt;
      elapsed_r <= elapsed_nxt;
      pub_r     <= pub_nxt;
    end
  end

  // stored command words are only read once have_r is set
  always_ff @(posedge clk) begin
    if (accept_i && item_i.req == REQ_DRIVE) begin
      thr_r <= item_i.thr;
      ste_r <= item_i.ste;
      brk_r <= item_i.brk;
      en_r  <= item_i.en;
      es_r  <= item_i.es;
      seq_r <= item_i.seq;
    end
  end

  assign cfg_o = cfg_r;
  assign st_o  = '{have_command: have_r, estop_latch: latch_r, elapsed_ms: elapsed_r,
                   thr: thr_r, ste: ste_r, brk: brk_r, en: en_r, es: es_r,
                   seq: seq_r, publish_count: pub_r};

endmodule

>>> sv/dcsg_eval.sv
// Combinational result logic: timeout, estop, deadzone/clamp, brake forcing, mix.
// Depends on dcsg_pkg.
module dcsg_eval import dcsg_pkg::*; (
  input  item_t       item_i,
  input  gate_state_t st_i,
  input  cfg_t        cfg_i,
  output logic        has_res_o,
  output logic        reset_ok_o,
  output res_t        res_o
);

  function automatic logic [16:0] abs17(input logic signed [15:0] v);
    logic signed [16:0] vx;
    vx = {v[15], v};
    return v[15] ? 17'(-vx) : 17'(vx);
  endfunction

  function automatic logic signed [15:0] gate_axis(input logic signed [15:0] v,
                                                   input logic [14:0] mx,
                                                   input logic [14:0] dz);
    logic signed [17:0] vx, hi;
    vx = {{2{v[15]}}, v};
    hi = {3'b000, mx};
    if (abs17(v) < {2'b00, dz}) return '0;
    if (vx > hi) return hi[15:0];
    if (vx < -hi) return 16'(-hi);
    return v;
  endfunction

  function automatic logic signed [15:0] clamp_one(input logic signed [17:0] v);
    logic signed [17:0] one;
    one = {{2{ONE_Q[15]}}, ONE_Q};
    if (v > one) return ONE_Q;
    if (v < -one) return 16'(-one);
    return v[15:0];
  endfunction

  logic               neutral, stale;
  logic signed [15:0] thr, ste, brk, brk_c;
  logic               en, es, fs;
  mode_t              mode;

  assign neutral = !st_i.have_command ||
                   (abs17(st_i.thr) <= {2'b00, cfg_i.deadzone} &&
                    abs17(st_i.ste) <= {2'b00, cfg_i.deadzone});
  assign reset_ok_o = !cfg_i.req_neutral || neutral;
  assign stale      = !st_i.have_command || (st_i.elapsed_ms > {1'b0, cfg_i.timeout_ms});
  assign has_res_o  = (item_i.req == REQ_RESET) || (item_i.req == REQ_PUBLISH);

  always_comb begin
    thr = '0;
    ste = '0;
    brk = ONE_Q;
    en  = 1'b0;
    es  = 1'b0;
    fs  = 1'b0;
    brk_c = st_i.brk[15] ? '0 : ((st_i.brk > ONE_Q) ? ONE_Q : st_i.brk);
    if (stale) begin
      // timeout wins over a latched stop but still reports the latch
      es   = st_i.estop_latch;
      fs   = 1'b1;
      mode = MODE_TIMEOUT;
    end else if (st_i.estop_latch) begin
      es   = 1'b1;
      fs   = 1'b1;
      mode = MODE_ESTOP;
    end else begin
      thr = gate_axis(st_i.thr, cfg_i.out_limit, cfg_i.deadzone);
      ste = gate_axis(st_i.ste, cfg_i.out_limit, cfg_i.deadzone);
      brk = brk_c;
      en  = st_i.en;
      es  = st_i.es;
      if (!st_i.en || brk_c >= HALF_Q) begin
        thr = '0;
        ste = '0;
        brk = ONE_Q;
        en  = st_i.en && !st_i.es;
      end
      mode = (abs17(thr) <= {2'b00, cfg_i.deadzone} &&
              abs17(ste) <= {2'b00, cfg_i.deadzone}) ? MODE_IDLE : MODE_DRIVE;
    end
  end

  always_comb begin
    res_o = '0;
    if (item_i.req == REQ_RESET) begin
      res_o.mode = reset_ok_o ? MODE_RST_OK : MODE_RST_DENY;
    end else begin
      res_o.safe_throttle = thr;
      res_o.safe_steering = ste;
      res_o.safe_brake    = brk[14:0];
      res_o.safe_enable   = en;
      res_o.safe_estop    = es;
      res_o.drive_seq     = st_i.have_command ? st_i.seq : '0;
      res_o.mode          = mode;
      res_o.failsafe      = fs;
      res_o.link_ok       = st_i.have_command && !stale;
      res_o.left_drive    = clamp_one(18'(thr) + 18'(ste));
      res_o.right_drive   = clamp_one(18'(thr) - 18'(ste));
      res_o.status_seq    = st_i.publish_count;
    end
  end

endmodule

>>> sv/dcsg_outbuf.sv
// Result register with a one-word skid stage so the input side keeps flowing.
// Depends on dcsg_pkg.
module dcsg_outbuf import dcsg_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_i,
  input  res_t res_i,
  input  logic out_stall_i,
  output logic out_valid_o,
  output res_t out_o,
  output logic full_o
);

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t out_r, out_nxt;
  res_t skid_r, skid_nxt;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (out_valid_r && out_stall_i) begin
      if (push_i) begin
        skid_valid_nxt = 1'b1;
        skid_nxt       = res_i;
      end
    end else if (skid_valid_r) begin
      out_valid_nxt  = 1'b1;
      out_nxt        = skid_r;
      skid_valid_nxt = push_i;
      if (push_i) skid_nxt = res_i;
    end else begin
      out_valid_nxt = push_i;
      if (push_i) out_nxt = res_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid_o = out_valid_r;
  assign out_o       = out_r;
  assign full_o      = skid_valid_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held with empty output register");

  a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall_i && push_i) |=> (skid_valid_r && skid_r == $past(res_i)))
    else $error("word pushed during stall not captured in skid");

  a_direct_load: assert property (@(posedge clk) disable iff (!rst_n)
    ((!out_valid_r || !out_stall_i) && !skid_valid_r && push_i)
      |=> (out_valid_r && out_r == $past(res_i)))
    else $error("pushed word not loaded into output register");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_stall_i) |=> (out_valid_r && out_r == $past(skid_r)))
    else $error("skid word lost when output drained");

endmodule

>>> sv/drive_command_safety_gate.sv
// Drive command safety gate top level: input handshake, state, result logic, output buffer.
// Latency: a reset or publish word shows on out_ the cycle after acceptance unless out_stall
// holds the output register; then it waits in the skid stage. Drive and tick items: no word.
// Throughput: one item per cycle; in_stall rises only when both buffer slots are occupied.
// Reset: synchronous active-low rst_n clears the watchdog, latch, publish counter and
// buffers, and loads the register defaults; config writes are always taken (cfg_ready=1).
module drive_command_safety_gate import dcsg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_req_type,
  input  logic signed [15:0]    in_throttle_in,
  input  logic signed [15:0]    in_steering_in,
  input  logic signed [15:0]    in_brake_in,
  input  logic                  in_enable_in,
  input  logic                  in_estop_in,
  input  logic [31:0]           in_cmd_seq,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [15:0]    out_safe_throttle,
  output logic signed [15:0]    out_safe_steering,
  output logic [14:0]           out_safe_brake,
  output logic                  out_safe_enable,
  output logic                  out_safe_estop,
  output logic [31:0]           out_drive_seq,
  output logic [2:0]            out_mode,
  output logic                  out_failsafe,
  output logic                  out_link_ok,
  output logic signed [15:0]    out_left_drive,
  output logic signed [15:0]    out_right_drive,
  output logic [31:0]           out_status_seq,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  item_t       item;
  gate_state_t st;
  cfg_t        cfg;
  res_t        res, out_word;
  logic        accept, has_res, reset_ok, full;

  assign item = '{req: req_t'(in_req_type), thr: in_throttle_in, ste: in_steering_in,
                  brk: in_brake_in, en: in_enable_in, es: in_estop_in, seq: in_cmd_seq};

  assign in_stall  = full;
  assign accept    = in_valid && !full;
  assign cfg_ready = 1'b1;

  dcsg_state u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept_i  (accept),
    .item_i    (item),
    .reset_ok_i(reset_ok),
    .cfg_we_i  (cfg_valid && cfg_ready),
    .cfg_idx_i (cfg_index),
    .cfg_data_i(cfg_data),
    .cfg_o     (cfg),
    .st_o      (st)
  );

  dcsg_eval u_eval (
    .item_i    (item),
    .st_i      (st),
    .cfg_i     (cfg),
    .has_res_o (has_res),
    .reset_ok_o(reset_ok),
    .res_o     (res)
  );

  dcsg_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (accept && has_res),
    .res_i      (res),
    .out_stall_i(out_stall),
    .out_valid_o(out_valid),
    .out_o      (out_word),
    .full_o     (full)
  );

  assign out_safe_throttle = out_word.safe_throttle;
  assign out_safe_steering = out_word.safe_steering;
  assign out_safe_brake    = out_word.safe_brake;
  assign out_safe_enable   = out_word.safe_enable;
  assign out_safe_estop    = out_word.safe_estop;
  assign out_drive_seq     = out_word.drive_seq;
  assign out_mode          = out_word.mode;
  assign out_failsafe      = out_word.failsafe;
  assign out_link_ok       = out_word.link_ok;
  assign out_left_drive    = out_word.left_drive;
  assign out_right_drive   = out_word.right_drive;
  assign out_status_seq    = out_word.status_seq;

endmodule
